// ===== rtl/core/sbtg_pkg.sv =====
// Shared types and fixed constants of the sine beep tone generator.
`default_nettype none

package sbtg_pkg;

  // Sample count width and its saturation limit
  localparam int unsigned CountW   = 21;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Tone amplitude and quarter-wave table entry width
  localparam int unsigned Amplitude = 20000;
  localparam int unsigned AmpW      = 15;
  localparam int unsigned SmpW      = 16;

  // pi in Q30, used to build the quarter-wave table
  localparam logic [63:0] PiQ30 = 64'd3373259426;

  // Milliseconds per second for the duration conversion
  localparam int unsigned MsPerSec = 1000;

  // Entries in the queue between front and back
  localparam int unsigned QueueDepth = 4;

  // One input request: a sample tick, optionally starting a beep
  typedef struct packed {
    logic        start_req;
    logic [14:0] freq_hz;
    logic [15:0] duration_ms;
  } in_item_t;

  // One stereo output frame
  typedef struct packed {
    logic signed [SmpW-1:0] left_sample;
    logic signed [SmpW-1:0] right_sample;
    logic                   last;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/sbtg_front.sv =====
// Front end: accepts ticks and converts frequency and duration to step and sample count.
`default_nettype none

module sbtg_front #(
  parameter int unsigned TICK_RATE_HZ = 16000,
  parameter int unsigned PHASE_BITS   = 32,
  localparam int unsigned EntryW      = 1 + PHASE_BITS + sbtg_pkg::CountW
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire sbtg_pkg::in_item_t in_item_i,
  input  wire logic               queue_full_i,
  output logic                    push_o,
  output logic [EntryW-1:0]       push_data_o
);

  typedef logic [PHASE_BITS-1:0] phase_t;

  localparam int unsigned XfW = 31;
  localparam int unsigned XnW = 32;
  localparam int unsigned QfW = 18;
  localparam int unsigned QnW = 22;

  // 2^PHASE_BITS = StepA * TICK_RATE_HZ + StepB
  localparam logic [63:0] PhaseOne = 64'd1 << PHASE_BITS;
  localparam phase_t      StepA    = phase_t'(PhaseOne / TICK_RATE_HZ);
  localparam logic [15:0] StepB    = 16'(PhaseOne % TICK_RATE_HZ);
  localparam logic [15:0] RateW    = 16'(TICK_RATE_HZ);
  // Reciprocals scaled by 2^32; estimates are low by at most one
  localparam logic [19:0] RecipF   = 20'((64'd1 << 32) / TICK_RATE_HZ);
  localparam logic [22:0] RecipN   = 23'((64'd1 << 32) / sbtg_pkg::MsPerSec);
  localparam logic [9:0]  MsW      = 10'(sbtg_pkg::MsPerSec);

  logic adv;

  logic           s1_valid_q, s2_valid_q, s3_valid_q;
  logic           s1_start_q, s2_start_q, s3_start_q;
  phase_t         s1_pa_q, s2_pa_q, s3_pa_q;
  logic [XfW-1:0] s1_xf_q, s2_xf_q, s3_xf_q;
  logic [XnW-1:0] s1_xn_q, s2_xn_q, s3_xn_q;
  logic [QfW-1:0] s2_qf_q, s3_qf_q;
  logic [QnW-1:0] s2_qn_q, s3_qn_q;
  logic [XfW-1:0] s3_mf_q;
  logic [XnW-1:0] s3_mn_q;

  logic [XfW-1:0] rem_f;
  logic [XnW-1:0] rem_n;
  logic [QfW-1:0] quo_f;
  logic [QnW-1:0] quo_n;
  phase_t         step;
  logic [sbtg_pkg::CountW-1:0] count;

  // Whole pipeline moves while its last stage can drain into the queue
  assign adv        = !s3_valid_q || !queue_full_i;
  assign in_ready_o = adv;
  assign push_o     = s3_valid_q && !queue_full_i;

  // Control: stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // Datapath: products, reciprocal estimates, back-multiplication
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage 1: split products
      s1_start_q <= in_item_i.start_req;
      s1_pa_q    <= phase_t'(phase_t'(in_item_i.freq_hz) * StepA);
      s1_xf_q    <= XfW'(in_item_i.freq_hz) * XfW'(StepB);
      s1_xn_q    <= XnW'(RateW) * XnW'(in_item_i.duration_ms);
      // stage 2: quotient estimates
      s2_start_q <= s1_start_q;
      s2_pa_q    <= s1_pa_q;
      s2_xf_q    <= s1_xf_q;
      s2_xn_q    <= s1_xn_q;
      s2_qf_q    <= QfW'((51'(s1_xf_q) * 51'(RecipF)) >> 32);
      s2_qn_q    <= QnW'((55'(s1_xn_q) * 55'(RecipN)) >> 32);
      // stage 3: estimate times divisor
      s3_start_q <= s2_start_q;
      s3_pa_q    <= s2_pa_q;
      s3_xf_q    <= s2_xf_q;
      s3_xn_q    <= s2_xn_q;
      s3_qf_q    <= s2_qf_q;
      s3_qn_q    <= s2_qn_q;
      s3_mf_q    <= XfW'(34'(s2_qf_q) * 34'(RateW));
      s3_mn_q    <= XnW'(32'(s2_qn_q) * 32'(MsW));
    end
  end

  // Stage 4: correct the estimates, form step and saturated count
  always_comb begin
    rem_f = s3_xf_q - s3_mf_q;
    rem_n = s3_xn_q - s3_mn_q;
    quo_f = s3_qf_q + QfW'(rem_f >= XfW'(RateW));
    quo_n = s3_qn_q + QnW'(rem_n >= XnW'(MsW));
    step  = phase_t'(s3_pa_q + phase_t'(quo_f));
    if (quo_n > QnW'(sbtg_pkg::CountMax)) begin
      count = sbtg_pkg::CountMax;
    end else begin
      count = sbtg_pkg::CountW'(quo_n);
    end
    push_data_o = {s3_start_q, step, count};
  end

endmodule

`default_nettype wire

// ===== rtl/core/sbtg_fifo.sv =====
// Small register queue between the front and back ends.
`default_nettype none

module sbtg_fifo #(
  parameter int unsigned WIDTH = 54,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      pop_data_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o     = (cnt_q == CntW'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sbtg_back.sv =====
// Back end: phase accumulator, sample counter and quarter-wave sine lookup.
`default_nettype none

module sbtg_back #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned SINE_TABLE_BITS = 10,
  localparam int unsigned EntryW         = 1 + PHASE_BITS + sbtg_pkg::CountW
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [EntryW-1:0]   q_data_i,
  input  wire logic                q_empty_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output sbtg_pkg::out_item_t      out_item_o
);

  typedef logic [PHASE_BITS-1:0]         phase_t;
  typedef logic [sbtg_pkg::CountW-1:0]   count_t;

  localparam int unsigned QuarterN    = 2 ** (SINE_TABLE_BITS - 2);
  localparam int unsigned AddrW       = SINE_TABLE_BITS - 1;
  localparam int unsigned PosW        = SINE_TABLE_BITS - 2;
  localparam logic [63:0] HalfTurnDiv = 64'(2 * QuarterN);
  localparam logic [63:0] DivTerm [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                          64'd110, 64'd156, 64'd210, 64'd272};

  // Table entry i: trunc(20000 * sin(pi/2 * i/QuarterN)), Taylor series in Q30
  function automatic logic [sbtg_pkg::AmpW-1:0] sine_entry(input int unsigned i);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        res;
    x    = (sbtg_pkg::PiQ30 * 64'(i)) / HalfTurnDiv;
    x2   = (x * x) >> 30;
    term = x;
    sum  = '0;
    for (int k = 0; k < 8; k++) begin
      if (k % 2 == 0) begin
        sum = sum + signed'(term);
      end else begin
        sum = sum - signed'(term);
      end
      term = ((term * x2) >> 30) / DivTerm[k];
    end
    if (sum < 0) begin
      sum = '0;
    end
    res = (unsigned'(sum) * 64'(sbtg_pkg::Amplitude)) >> 30;
    return sbtg_pkg::AmpW'(res);
  endfunction

  // Quarter-wave table, last entry is the full amplitude
  logic [sbtg_pkg::AmpW-1:0] rom_tbl [QuarterN + 1];

  for (genvar g = 0; g < QuarterN; g++) begin : g_rom
    localparam logic [sbtg_pkg::AmpW-1:0] Val = sine_entry(g);
    assign rom_tbl[g] = Val;
  end
  assign rom_tbl[QuarterN] = sbtg_pkg::AmpW'(sbtg_pkg::Amplitude);

  logic   en, pop;
  logic   e_start;
  phase_t e_step;
  count_t e_count;
  phase_t cur_phase, cur_inc;
  count_t cur_cnt;
  logic   emit;

  logic [SINE_TABLE_BITS-1:0] idx;
  logic [PosW-1:0]            pos;
  logic [AddrW-1:0]           addr;

  phase_t phase_q, inc_q;
  count_t cnt_q;

  logic             a_valid_q, a_neg_q, a_last_q;
  logic [AddrW-1:0] a_addr_q;

  logic                out_valid_q;
  sbtg_pkg::out_item_t out_q;

  logic [sbtg_pkg::SmpW-1:0]        mag;
  logic signed [sbtg_pkg::SmpW-1:0] smp;

  // Pipeline moves unless the output frame is stalled
  assign en      = !out_valid_q || out_ready_i;
  assign pop     = en && !q_empty_i;
  assign q_pop_o = pop;

  // Apply a queued tick to the tone state
  always_comb begin
    e_start   = q_data_i[EntryW-1];
    e_step    = q_data_i[EntryW-2 -: PHASE_BITS];
    e_count   = q_data_i[sbtg_pkg::CountW-1:0];
    cur_phase = e_start ? '0 : phase_q;
    cur_inc   = e_start ? e_step : inc_q;
    cur_cnt   = e_start ? e_count : cnt_q;
    emit      = (cur_cnt != '0);
    idx       = cur_phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
    pos       = idx[PosW-1:0];
    addr      = idx[SINE_TABLE_BITS-2] ? AddrW'(QuarterN) - AddrW'(pos) : AddrW'(pos);
  end

  // Tone state and stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      inc_q       <= '0;
      cnt_q       <= '0;
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        phase_q <= emit ? phase_t'(cur_phase + cur_inc) : cur_phase;
        inc_q   <= cur_inc;
        cnt_q   <= emit ? count_t'(cur_cnt - 1'b1) : cur_cnt;
      end
      if (en) begin
        a_valid_q   <= pop && emit;
        out_valid_q <= a_valid_q;
      end
    end
  end

  // Table read and sign
  always_comb begin
    mag = sbtg_pkg::SmpW'(rom_tbl[a_addr_q]);
    smp = a_neg_q ? signed'(sbtg_pkg::SmpW'(-mag)) : signed'(mag);
  end

  // Lookup address and output frame
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_addr_q           <= addr;
      a_neg_q            <= idx[SINE_TABLE_BITS-1];
      a_last_q           <= (cur_cnt == count_t'(1));
      out_q.left_sample  <= smp;
      out_q.right_sample <= smp;
      out_q.last         <= a_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/sine_beep_tone_generator.sv =====
// Beep tone generator top level: front end, request queue and sine back end.
//
// Usage: every request on the input channel is one sample tick. A request with
// start_req set begins a new beep at freq_hz lasting duration_ms; it replaces
// any beep in progress. Each tick while a beep runs (the start tick included)
// yields one stereo frame on the output channel; the final frame has last set.
// Ticks with no beep running yield nothing.
// Path: the tick enters the first of three front stages at the edge that
// accepts it, then passes through the queue, the phase update and the
// registered table read before its frame is offered.
// Throughput: one tick per cycle while frames are taken, set by the phase
// accumulator update in the back end.
// Reset: no beep runs, phase and step are zero, the queue is empty and no
// frame is offered.
// Stall: a frame not taken holds on the output; the back end stops, the
// 4-entry queue fills, and then in_ready_o drops until frames are taken.
`default_nettype none

module sine_beep_tone_generator #(
  parameter int unsigned TICK_RATE_HZ    = 16000,
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire sbtg_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output sbtg_pkg::out_item_t      out_item_o
);

  localparam int unsigned EntryW = 1 + PHASE_BITS + sbtg_pkg::CountW;

  logic              push, pop, full, empty;
  logic [EntryW-1:0] push_data, pop_data;

  // Tick acceptance and parameter conversion
  sbtg_front #(
    .TICK_RATE_HZ (TICK_RATE_HZ),
    .PHASE_BITS   (PHASE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .queue_full_i (full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  // Decoupling queue
  sbtg_fifo #(
    .WIDTH (EntryW),
    .DEPTH (sbtg_pkg::QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (full),
    .empty_o     (empty)
  );

  // Tone synthesis
  sbtg_back #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_data_i    (pop_data),
    .q_empty_i   (empty),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/sbtg_checker.sv =====
// Port-level checker for the beep tone generator, bound to the top level.
`default_nettype none

module sbtg_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire sbtg_pkg::in_item_t  in_item_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire sbtg_pkg::out_item_t out_item_o
);

  // Both channels always carry the same sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.left_sample == out_item_o.right_sample))
    else $error("left and right samples differ");

  // Samples stay within the tone amplitude
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_item_o.left_sample <= 16'sd20000) &&
                     (out_item_o.left_sample >= -16'sd20000)))
    else $error("sample outside amplitude range");

  // A stalled frame stays offered and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled output frame changed");

  // A stalled input request stays offered and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=> (in_valid_i && $stable(in_item_i)))
    else $error("stalled input request changed");

  // No frame is offered in the cycle after reset is sampled low
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("frame offered right after reset");

endmodule

bind sine_beep_tone_generator sbtg_checker u_sbtg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the sine beep tone generator.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TickRate   = 16000;
  localparam int unsigned QuarterN   = 256;
  localparam int unsigned ToneAmp    = 20000;
  localparam int unsigned RandTicks  = 950;
  localparam int unsigned DrainTicks = 24;
  localparam longint unsigned PiFix  = 64'd3373259426;
  localparam logic [20:0] FrameMax   = 21'h1F_FFFF;

  // Tracks the tone state and holds the frames still owed by the block
  class beep_tracker;
    int                  quarter_wave[QuarterN+1];
    logic [31:0]         phase;
    logic [31:0]         step;
    logic [20:0]         remaining;
    sbtg_pkg::out_item_t frames_due[$];
    int unsigned         errors;

    function new();
      for (int i = 0; i < QuarterN; i++) quarter_wave[i] = quarter_point(i);
      quarter_wave[QuarterN] = ToneAmp;
      phase     = '0;
      step      = '0;
      remaining = '0;
      errors    = 0;
    endfunction

    // Q30 Taylor series of sin up to x^15, scaled and truncated
    function int quarter_point(int unsigned i);
      longint unsigned x, x2, term;
      longint          acc;
      x    = (PiFix * longint'(i)) / (2 * QuarterN);
      x2   = (x * x) >> 30;
      term = x;
      acc  = 0;
      for (int k = 0; k < 8; k++) begin
        if (k % 2 == 0) acc += longint'(term);
        else acc -= longint'(term);
        term = ((term * x2) >> 30) / longint'((2 * k + 2) * (2 * k + 3));
      end
      if (acc < 0) acc = 0;
      return int'((longint'(acc) * ToneAmp) >> 30);
    endfunction

    // Quarter-wave lookup: mirror in odd quadrants, negate in the lower half
    function logic signed [15:0] tone_sample(logic [31:0] ph);
      logic [1:0] quad;
      logic [7:0] pos;
      int         v;
      quad = ph[31:30];
      pos  = ph[29:22];
      v    = quad[0] ? quarter_wave[QuarterN - pos] : quarter_wave[pos];
      if (quad[1]) v = -v;
      return v[15:0];
    endfunction

    // An accepted tick request: maybe restart, then owe one frame if running
    function void note_tick(sbtg_pkg::in_item_t t);
      longint unsigned     inc, cnt;
      sbtg_pkg::out_item_t f;
      if (t.start_req) begin
        inc       = (longint'(t.freq_hz) << 32) / TickRate;
        cnt       = (longint'(TickRate) * t.duration_ms) / 1000;
        phase     = '0;
        step      = inc[31:0];
        remaining = (cnt > FrameMax) ? FrameMax : cnt[20:0];
      end
      if (remaining != 0) begin
        f.left_sample  = tone_sample(phase);
        f.right_sample = f.left_sample;
        f.last         = (remaining == 1);
        frames_due.push_back(f);
        phase     = phase + step;
        remaining = remaining - 1;
      end
    endfunction

    // An accepted output frame against the oldest frame owed
    function void check_frame(sbtg_pkg::out_item_t got);
      sbtg_pkg::out_item_t exp_f;
      if (frames_due.size() == 0) begin
        $error("unexpected frame: left %0d right %0d last %0b",
               $signed(got.left_sample), $signed(got.right_sample), got.last);
        errors++;
        return;
      end
      exp_f = frames_due.pop_front();
      if (got.left_sample !== exp_f.left_sample) begin
        $error("left_sample: expected %0d, got %0d",
               $signed(exp_f.left_sample), $signed(got.left_sample));
        errors++;
      end
      if (got.right_sample !== exp_f.right_sample) begin
        $error("right_sample: expected %0d, got %0d",
               $signed(exp_f.right_sample), $signed(got.right_sample));
        errors++;
      end
      if (got.last !== exp_f.last) begin
        $error("last: expected %0b, got %0b", exp_f.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  sbtg_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  sbtg_pkg::out_item_t out_item;

  beep_tracker tracker;

  sine_beep_tone_generator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  always #5 clk_i = ~clk_i;

  // Run limit
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Present one tick request after an idle gap and wait for its acceptance
  task automatic send_tick(input sbtg_pkg::in_item_t t, input int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= t;
    do @(posedge clk_i); while (!in_ready);
    tracker.note_tick(t);
  endtask

  function automatic sbtg_pkg::in_item_t tick_item(bit start, int unsigned freq,
                                                   int unsigned ms);
    sbtg_pkg::in_item_t t;
    t.start_req   = start;
    t.freq_hz     = freq[14:0];
    t.duration_ms = ms[15:0];
    return t;
  endfunction

  // Random tick: mostly plain ticks with noise payload, sometimes a new beep
  function automatic sbtg_pkg::in_item_t random_tick();
    sbtg_pkg::in_item_t t;
    t.start_req   = ($urandom_range(0, 23) == 0);
    t.freq_hz     = 15'($urandom_range(0, 24000));
    t.duration_ms = 16'($urandom_range(0, 65535));
    if (t.start_req) begin
      case ($urandom_range(0, 9))
        0:       t.duration_ms = 16'd0;
        1, 2, 3: t.duration_ms = 16'd1;
        4, 5, 6: t.duration_ms = 16'd2;
        7, 8:    t.duration_ms = 16'($urandom_range(3, 12));
        default: t.duration_ms = 16'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 7))
        0:       t.freq_hz = 15'd0;
        1:       t.freq_hz = 15'd24000;
        2:       t.freq_hz = 15'(TickRate);
        default: t.freq_hz = 15'($urandom_range(0, 24000));
      endcase
    end
    return t;
  endfunction

  function automatic int unsigned idle_gap(bit no_idle);
    return no_idle ? 0 : $urandom_range(0, 19);
  endfunction

  // Output side: random stalls per frame, with stall-free stretches
  initial begin
    int unsigned gap;
    int unsigned n;
    bit          no_stall;
    n        = 0;
    no_stall = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (n % 40 == 0) no_stall = ($urandom_range(0, 3) == 0);
      n++;
      gap = idle_gap(no_stall);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      tracker.check_frame(out_item);
    end
  end

  // Main sequence: reset, directed ticks, random ticks, drain
  initial begin
    sbtg_pkg::in_item_t directed[$];
    bit                 no_idle;
    tracker = new();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle tick, short beeps, max duration at top frequency, step wrap at the
    // sample rate, zero length cutting a beep, then a full quadrant beep
    directed.push_back(tick_item(1'b0, 24000, 65535));
    directed.push_back(tick_item(1'b1, 0, 1));
    directed.push_back(tick_item(1'b0, 0, 0));
    directed.push_back(tick_item(1'b1, 24000, 65535));
    directed.push_back(tick_item(1'b0, 12345, 4321));
    directed.push_back(tick_item(1'b0, 24000, 65535));
    directed.push_back(tick_item(1'b1, 16000, 2));
    directed.push_back(tick_item(1'b0, 1, 1));
    directed.push_back(tick_item(1'b1, 4000, 0));
    directed.push_back(tick_item(1'b0, 3000, 7));
    directed.push_back(tick_item(1'b1, 4000, 1));
    repeat (15) directed.push_back(tick_item(1'b0, 0, 0));

    no_idle = 1'b0;
    foreach (directed[i]) send_tick(directed[i], idle_gap(i > 15));

    for (int i = 0; i < RandTicks; i++) begin
      if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_tick(random_tick(), idle_gap(no_idle));
    end
    in_valid <= 1'b0;

    // Wait for every owed frame, then watch for strays
    while (tracker.frames_due.size() != 0) @(posedge clk_i);
    repeat (DrainTicks) @(posedge clk_i);

    if (tracker.errors == 0 && tracker.frames_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
